@@ rtl/urld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_pkg
// Types, character codes and helpers shared by the percent decoder modules.
// ----------------------------------------------------------------------------
package urld_pkg;

	localparam int FIFO_DEPTH_DEF = 4;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [1:0] HELD_IDLE  = 2'd0;
	localparam logic [1:0] HELD_PCT   = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} enc_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} dec_item_t;

	// Up to three bytes to emit; last applies to the final one.
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Valid only for hex digit characters.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return c[3:0] + (c[6] ? 4'd9 : 4'd0);
	endfunction

endpackage

@@ rtl/urld_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_front
// Escape tracker: classifies each accepted byte and issues an emit command when bytes are due.
// ----------------------------------------------------------------------------
module urld_front import urld_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  enc_item_t enc,
	output logic      cmd_valid,
	output cmd_t      cmd
);

	logic [1:0] held_q;
	logic [7:0] digit_q;
	logic [1:0] held_d;
	logic       ib_emit;
	logic [7:0] ib_byte;
	logic       b_hex;
	logic       b_pct;

	assign b_hex = is_hex(enc.in_byte);
	assign b_pct = (enc.in_byte == CH_PERCENT);

	always_comb begin
		ib_emit = !(b_pct && !enc.in_last);
		if (b_pct) begin
			ib_byte = CH_PERCENT;
		end else if (enc.in_byte == CH_PLUS) begin
			ib_byte = CH_SPACE;
		end else begin
			ib_byte = enc.in_byte;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.last = enc.in_last;
		held_d   = (b_pct && !enc.in_last) ? HELD_PCT : HELD_IDLE;
		unique case (held_q)
			HELD_PCT: begin
				if (b_hex && !enc.in_last) begin
					held_d = HELD_DIGIT;
				end else begin
					cmd.n  = 2'd1 + {1'b0, ib_emit};
					cmd.b0 = CH_PERCENT;
					cmd.b1 = ib_byte;
				end
			end
			HELD_DIGIT: begin
				if (b_hex) begin
					held_d = HELD_IDLE;
					cmd.n  = 2'd1;
					cmd.b0 = {hex_val(digit_q), hex_val(enc.in_byte)};
				end else begin
					cmd.n  = 2'd2 + {1'b0, ib_emit};
					cmd.b0 = CH_PERCENT;
					cmd.b1 = digit_q;
					cmd.b2 = ib_byte;
				end
			end
			default: begin
				cmd.n  = {1'b0, ib_emit};
				cmd.b0 = ib_byte;
			end
		endcase
	end

	assign cmd_valid = accept && (cmd.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_IDLE;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_q == HELD_PCT) begin
			digit_q <= enc.in_byte;
		end
	end

endmodule

@@ rtl/urld_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_fifo
// Small command queue between the escape tracker and the byte emitter.
// ----------------------------------------------------------------------------
module urld_fifo import urld_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  cmd_t       wr_data,
	input  logic       rd_en,
	output cmd_t       rd_data,
	output fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/urld_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urld_back
// Byte emitter: walks each queued command and fills the output register.
// ----------------------------------------------------------------------------
module urld_back import urld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  fifo_stat_t stat,
	output logic       head_pop,
	input  logic       pop,
	output logic       empty,
	output dec_item_t  dec
);

	logic [1:0] idx_q;
	logic       ovalid_q;
	dec_item_t  out_q;
	logic       take;
	logic       final_b;
	logic [7:0] sel_byte;

	assign take     = !stat.empty && (!ovalid_q || pop);
	assign final_b  = (idx_q == head.n - 2'd1);
	assign head_pop = take && final_b;
	assign empty    = !ovalid_q;
	assign dec      = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			default: sel_byte = head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q    <= final_b ? 2'd0 : idx_q + 2'd1;
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.out_byte <= sel_byte;
			out_q.out_last <= head.last && final_b;
		end
	end

endmodule

@@ rtl/url_percent_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming URL percent decoder: one byte in per cycle unless full, decoded out.
// Path: an accepted byte's command is written into the queue, then its first
// byte is registered on dec; further bytes of a command follow one per cycle while popped.
// Throughput: one input byte per cycle unless full; one decoded byte per cycle while
// popped, set by the single output register; a failed escape emits up to three
// bytes, absorbed by the FIFO_DEPTH-command queue that backpressures through full.
// Reset: arst_n clears the escape state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module url_percent_decoder_core import urld_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  enc_item_t enc,
	output logic      empty,
	input  logic      pop,
	output dec_item_t dec
);

	logic       accept;
	logic       cmd_valid;
	cmd_t       cmd;
	cmd_t       head;
	logic       head_pop;
	fifo_stat_t fstat;

	assign full   = fstat.full;
	assign accept = push && !fstat.full;

	urld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.enc       (enc),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	urld_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (head_pop),
		.rd_data (head),
		.stat    (fstat)
	);

	urld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (fstat),
		.head_pop (head_pop),
		.pop      (pop),
		.empty    (empty),
		.dec      (dec)
	);

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fstat.empty && fstat.full))
		else $error("queue both empty and full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> !fstat.empty)
		else $error("command popped from empty queue");

	a_cmd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.n != 2'd0 && !fstat.full))
		else $error("bad command transfer");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(dec)))
		else $error("result changed while stalled");

endmodule

@@ bench/tb_url_percent_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_core
// Self-checking bench for the streaming URL percent decoder. Encoded strings
// are sent byte by byte through the push/full side. A cycle-free predictor
// tracks the escape state and queues the decoded bytes each transfer should
// produce. The pop/empty side is compared against that queue in order.
// Stimulus is a directed set of escape edge cases, then random strings that
// are mostly well-formed with some broken escapes. The run covers three
// stall mixes on the two sides.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_core;
	import urld_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full;
	logic      empty;
	enc_item_t enc = '0;
	dec_item_t dec;

	enc_item_t  pend_enc[$];
	dec_item_t  want_dec[$];
	dec_item_t  want;
	logic [1:0] esc_state = HELD_IDLE;
	logic [7:0] esc_digit = 8'h00;
	int         send_idle = 18;
	int         recv_idle = 61;
	int         errors = 0;

	url_percent_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.enc    (enc),
		.empty  (empty),
		.pop    (pop),
		.dec    (dec)
	);

	always #5 clk = ~clk;

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= "a")
			return 4'(c - "a" + 10);
		if (c >= "A")
			return 4'(c - "A" + 10);
		return 4'(c - "0");
	endfunction

	function automatic void expect_byte(input logic [7:0] b, input logic l);
		want_dec.push_back(dec_item_t'{out_byte: b, out_last: l});
	endfunction

	// byte handled from the idle state
	function automatic void decode_plain(input logic [7:0] b, input logic l);
		esc_state = HELD_IDLE;
		if (b == CH_PERCENT) begin
			if (l)
				expect_byte(CH_PERCENT, 1'b1);
			else
				esc_state = HELD_PCT;
		end else if (b == CH_PLUS) begin
			expect_byte(CH_SPACE, l);
		end else begin
			expect_byte(b, l);
		end
	endfunction

	function automatic void decode_char(input enc_item_t it);
		case (esc_state)
			HELD_PCT: begin
				if (is_hex_char(it.in_byte) && !it.in_last) begin
					esc_digit = it.in_byte;
					esc_state = HELD_DIGIT;
				end else begin
					expect_byte(CH_PERCENT, 1'b0);
					decode_plain(it.in_byte, it.in_last);
				end
			end
			HELD_DIGIT: begin
				if (is_hex_char(it.in_byte)) begin
					expect_byte({nibble_of(esc_digit), nibble_of(it.in_byte)}, it.in_last);
					esc_state = HELD_IDLE;
				end else begin
					expect_byte(CH_PERCENT, 1'b0);
					expect_byte(esc_digit, 1'b0);
					decode_plain(it.in_byte, it.in_last);
				end
			end
			default: decode_plain(it.in_byte, it.in_last);
		endcase
		if (it.in_last)
			esc_state = HELD_IDLE;
	endfunction

	task automatic add_chars(input logic [7:0] chars[$]);
		for (int i = 0; i < chars.size(); i++)
			pend_enc.push_back(enc_item_t'{in_byte: chars[i], in_last: i == chars.size() - 1});
	endtask

	task automatic add_text(input string s);
		logic [7:0] chars[$];
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
		add_chars(chars);
	endtask

	task automatic add_random_string();
		string      hexset;
		logic [7:0] chars[$];
		logic [7:0] b;
		int         n;
		int         r;
		hexset = "0123456789abcdefABCDEF";
		n = $urandom_range(8, 1);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 50) begin
				chars.push_back(CH_PERCENT);
				chars.push_back(hexset[$urandom_range(21)]);
				chars.push_back(hexset[$urandom_range(21)]);
			end else if (r < 65) begin
				chars.push_back(CH_PLUS);
			end else if (r < 90) begin
				do
					b = 8'($urandom_range(255, 1));
				while (b == CH_PERCENT);
				chars.push_back(b);
			end else begin
				case ($urandom_range(2))
					0: chars.push_back(CH_PERCENT);
					1: begin
						chars.push_back(CH_PERCENT);
						chars.push_back(hexset[$urandom_range(21)]);
					end
					default: chars.push_back(8'($urandom_range(255, 1)));
				endcase
			end
		end
		add_chars(chars);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				decode_char(enc);
			if (!push || !full) begin
				if (pend_enc.size() != 0 && $urandom_range(99) >= send_idle) begin
					enc  <= pend_enc.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (want_dec.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: byte %h last %b", dec.out_byte,
							dec.out_last);
				end else begin
					want = want_dec.pop_front();
					if (dec.out_byte !== want.out_byte || dec.out_last !== want.out_last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected byte %h last %b, got byte %h last %b",
								want.out_byte, want.out_last, dec.out_byte, dec.out_last);
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		logic [7:0] one[$];
		int         start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_text("%41");
		add_text("%fF");
		add_text("%00");
		add_text("a+b");
		add_text("%");
		add_text("%4");
		add_text("%4G");
		add_text("%4%41");
		one.push_back(8'hFF);
		add_chars(one);
		one[0] = 8'h01;
		add_chars(one);
		for (int p = 0; p < 3; p++) begin
			@(negedge clk);
			send_idle = (p == 0) ? 18 : (p == 1) ? 61 : 0;
			recv_idle = (p == 0) ? 61 : (p == 1) ? 18 : 0;
			start = pend_enc.size();
			while (pend_enc.size() - start < 85)
				add_random_string();
			while (pend_enc.size() != 0 || push || want_dec.size() != 0)
				@(negedge clk);
			repeat (5) @(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (errors == 0 && want_dec.size() == 0)
			$display("url_percent_decoder_core regression: pass");
		else
			$display("url_percent_decoder_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("url_percent_decoder_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/urld_pkg.sv
rtl/urld_front.sv
rtl/urld_fifo.sv
rtl/urld_back.sv
rtl/url_percent_decoder_core.sv
bench/tb_url_percent_decoder_core.sv
